@@ rtl/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg
// Shared constants for the segment intersection test pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

  // default coordinate width (two's complement, 1.0 = 2^14 at 16 bits)
  localparam int COORD_BITS_DEF = 16;

  // register stages from input beat to result beat
  localparam int NUM_STAGES = 5;

endpackage
// ----------------------------------------------------------------------------

@@ rtl/sit_datapath.sv @@
// ----------------------------------------------------------------------------
// sit_datapath
// Five-stage arithmetic pipe: differences, products, cross/dot sums,
// sign normalization, final range compares. Stage k loads when adv[k-1] is set.
// ----------------------------------------------------------------------------
module sit_datapath
  import sit_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic [NUM_STAGES-1:0]        adv,
  input  logic signed [COORD_BITS-1:0] ax_start,
  input  logic signed [COORD_BITS-1:0] ay_start,
  input  logic signed [COORD_BITS-1:0] ax_end,
  input  logic signed [COORD_BITS-1:0] ay_end,
  input  logic signed [COORD_BITS-1:0] bx_start,
  input  logic signed [COORD_BITS-1:0] by_start,
  input  logic signed [COORD_BITS-1:0] bx_end,
  input  logic signed [COORD_BITS-1:0] by_end,
  output logic                         crossing,
  output logic                         collinear,
  output logic                         degenerate
);

  localparam int DW = COORD_BITS + 1;     // coordinate difference
  localparam int PW = 2 * COORD_BITS + 2; // product of two differences
  localparam int CW = 2 * COORD_BITS + 3; // sum of two products
  localparam int NW = 2 * COORD_BITS + 4; // sum of two such sums

  // stage 1: segment direction and offset vectors
  logic signed [DW-1:0] rx_r, ry_r, sx_r, sy_r, dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rx_r <= DW'(ax_end) - DW'(ax_start);
      ry_r <= DW'(ay_end) - DW'(ay_start);
      sx_r <= DW'(bx_end) - DW'(bx_start);
      sy_r <= DW'(by_end) - DW'(by_start);
      dx_r <= DW'(bx_start) - DW'(ax_start);
      dy_r <= DW'(by_start) - DW'(ay_start);
    end
  end

  // stage 2: all partial products, one multiplier each
  logic signed [PW-1:0] rxsy_r, rysx_r, dxsy_r, dysx_r, dxry_r, dyrx_r;
  logic signed [PW-1:0] rxrx_r, ryry_r, dxrx_r, dyry_r, sxrx_r, syry_r;
  logic                 deg2_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      rxsy_r <= rx_r * sy_r;
      rysx_r <= ry_r * sx_r;
      dxsy_r <= dx_r * sy_r;
      dysx_r <= dy_r * sx_r;
      dxry_r <= dx_r * ry_r;
      dyrx_r <= dy_r * rx_r;
      rxrx_r <= rx_r * rx_r;
      ryry_r <= ry_r * ry_r;
      dxrx_r <= dx_r * rx_r;
      dyry_r <= dy_r * ry_r;
      sxrx_r <= sx_r * rx_r;
      syry_r <= sy_r * ry_r;
      deg2_r <= (rx_r == '0) && (ry_r == '0);
    end
  end

  // stage 3: cross products and dot products
  logic signed [CW-1:0] den_r, tn_r, un_r, rr_r, n0_r, sdr_r;
  logic                 deg3_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      den_r  <= CW'(rxsy_r) - CW'(rysx_r);
      tn_r   <= CW'(dxsy_r) - CW'(dysx_r);
      un_r   <= CW'(dxry_r) - CW'(dyrx_r);
      rr_r   <= CW'(rxrx_r) + CW'(ryry_r);
      n0_r   <= CW'(dxrx_r) + CW'(dyry_r);
      sdr_r  <= CW'(sxrx_r) + CW'(syry_r);
      deg3_r <= deg2_r;
    end
  end

  // stage 4: fold the denominator sign into the numerators, far end of B
  logic signed [CW-1:0] tnf_r, unf_r, dabs_r, rr4_r;
  logic signed [NW-1:0] n0w_r, n1w_r;
  logic                 den_zero_r, un_zero_r, deg4_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      tnf_r      <= den_r[CW-1] ? -tn_r : tn_r;
      unf_r      <= den_r[CW-1] ? -un_r : un_r;
      dabs_r     <= den_r[CW-1] ? -den_r : den_r;
      rr4_r      <= rr_r;
      n0w_r      <= NW'(n0_r);
      n1w_r      <= NW'(n0_r) + NW'(sdr_r);
      den_zero_r <= (den_r == '0);
      un_zero_r  <= (un_r == '0);
      deg4_r     <= deg3_r;
    end
  end

  // stage 5: range tests and result bits
  logic signed [NW-1:0] lo, hi;
  logic                 gen_ok, col_ok, on_line;
  logic                 crossing_r, collinear_r, degenerate_r;

  always_comb begin
    if (n1w_r <= n0w_r) begin
      lo = n1w_r;
      hi = n0w_r;
    end else begin
      lo = n0w_r;
      hi = n1w_r;
    end
    // t and u both in [0,1]
    gen_ok  = !tnf_r[CW-1] && (tnf_r <= dabs_r) && !unf_r[CW-1] && (unf_r <= dabs_r);
    // projected interval of B meets [0, r.r]
    col_ok  = !hi[NW-1] && (lo <= NW'(rr4_r));
    on_line = den_zero_r && un_zero_r;
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      degenerate_r <= deg4_r;
      collinear_r  <= !deg4_r && on_line;
      crossing_r   <= !deg4_r && (den_zero_r ? (un_zero_r && col_ok) : gen_ok);
    end
  end

  assign crossing   = crossing_r;
  assign collinear  = collinear_r;
  assign degenerate = degenerate_r;

endmodule
// ----------------------------------------------------------------------------

@@ rtl/segment_intersection_test_top.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_test_top
// Tests two 2D segments for touching, crossing or collinear overlap.
// ----------------------------------------------------------------------------
// Takes one segment pair per clock while in_stall is low and returns one
// result beat per pair, in order. Each pair passes through the five-stage
// arithmetic pipe (differences, products, cross/dot sums, sign folding,
// range compares) before out_valid rises. Each stage holds its beat
// only while the stage after it is full and blocked, so bubbles close up
// under a stalled output and in_stall rises only when all stages are full.
// A zero-length first segment reports degenerate with crossing and collinear
// cleared. All arithmetic is exact; no rounding.
module segment_intersection_test_top
  import sit_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_ax_start,
  input  logic signed [COORD_BITS-1:0] in_ay_start,
  input  logic signed [COORD_BITS-1:0] in_ax_end,
  input  logic signed [COORD_BITS-1:0] in_ay_end,
  input  logic signed [COORD_BITS-1:0] in_bx_start,
  input  logic signed [COORD_BITS-1:0] in_by_start,
  input  logic signed [COORD_BITS-1:0] in_bx_end,
  input  logic signed [COORD_BITS-1:0] in_by_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_crossing,
  output logic                         out_collinear,
  output logic                         out_degenerate
);

  // per-stage valid bits and advance enables
  logic [NUM_STAGES-1:0] vld_r, vld_nxt;
  logic [NUM_STAGES-1:0] adv;
  logic [NUM_STAGES-1:0] feed;

  always_comb begin
    adv[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  // valid feeding each stage: input valid, then the stage before
  assign feed = {vld_r[NUM_STAGES-2:0], in_valid};

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      vld_nxt[k] = adv[k] ? feed[k] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // arithmetic pipe
  sit_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .adv        (adv),
    .ax_start   (in_ax_start),
    .ay_start   (in_ay_start),
    .ax_end     (in_ax_end),
    .ay_end     (in_ay_end),
    .bx_start   (in_bx_start),
    .by_start   (in_by_start),
    .bx_end     (in_bx_end),
    .by_end     (in_by_end),
    .crossing   (out_crossing),
    .collinear  (out_collinear),
    .degenerate (out_degenerate)
  );

`ifndef SYNTHESIS
  // input blocks only when every stage holds a beat
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled with a bubble in the pipe");

  // degenerate first segment reports nothing else
  a_deg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (!out_crossing && !out_collinear))
    else $error("degenerate beat carries crossing or collinear");

  // a beat leaving the output advances the last stage from its feeder
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !vld_r[NUM_STAGES-2]) |=> !out_valid)
    else $error("output beat repeated");
`endif

endmodule
// ----------------------------------------------------------------------------
